@@ rtl/rws_pkg.sv @@
// Package with the types, constants and helper functions of the roulette wheel select core.
package rws_pkg;

  localparam int MaxMembers = 16;
  localparam int IdxW       = $clog2(MaxMembers);
  localparam int CntW       = $clog2(MaxMembers + 1);
  localparam int FitW       = 16;
  localparam int FracW      = 16;
  localparam int MaskW      = 16;
  localparam int MaskIdxW   = $clog2(MaskW);
  localparam int SumW       = FitW + IdxW;
  localparam int CfgW       = 5;
  localparam int CfgAddrW   = 3;
  localparam int CfgDataW   = 32;

  localparam logic [CfgW-1:0] MemberCountReset = CfgW'(16);

  // Word index of the configuration registers.
  localparam logic [CfgAddrW-3:0] RegMemberCount = '0;

  localparam logic CmdWrite  = 1'b0;
  localparam logic CmdSelect = 1'b1;

  localparam logic StatusOk      = 1'b0;
  localparam logic StatusMaskErr = 1'b1;

  typedef struct packed {
    logic            cmd;
    logic [3:0]      member_index;
    logic [FitW-1:0] fitness_value;
    logic [15:0]     random_fraction;
    logic [15:0]     exclude_mask;
  } in_word_t;

  typedef struct packed {
    logic [3:0] picked_index;
    logic       status;
  } out_word_t;

  typedef enum logic [2:0] {
    StIdle,
    StCheck,
    StSum,
    StMul,
    StScan,
    StResult
  } state_e;

  typedef struct packed {
    logic write_en;
    logic capture;
    logic sum_step;
    logic mul_load;
    logic scan_step;
    logic out_load;
  } ctrl_cmd_t;

  typedef struct packed {
    logic mask_err;
    logic last_elem;
    logic hit;
  } dp_status_t;

  // The member count in use, clamped to one through the table depth.
  function automatic logic [CntW-1:0] eff_count(input logic [CfgW-1:0] cfg);
    logic [CntW-1:0] n;
    n = CntW'(cfg);
    if (cfg == '0) begin
      n = CntW'(1);
    end else if (int'(cfg) > MaxMembers) begin
      n = CntW'(MaxMembers);
    end
    return n;
  endfunction

endpackage

@@ rtl/rws_ctrl.sv @@
// Controller state machine that sequences the sum, scale and scan passes of a select.
module rws_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  input  logic                in_cmd_i,
  input  logic                out_stall_i,
  input  rws_pkg::dp_status_t sts_i,
  output rws_pkg::ctrl_cmd_t  cmd_o,
  output logic                in_stall_o,
  output logic                out_valid_o
);

  rws_pkg::state_e state_q, state_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rws_pkg::StIdle: begin
        if (in_valid_i && (in_cmd_i == rws_pkg::CmdSelect)) begin
          state_d = rws_pkg::StCheck;
        end
      end
      rws_pkg::StCheck: begin
        state_d = sts_i.mask_err ? rws_pkg::StResult : rws_pkg::StSum;
      end
      rws_pkg::StSum: begin
        if (sts_i.last_elem) begin
          state_d = rws_pkg::StMul;
        end
      end
      rws_pkg::StMul: begin
        state_d = rws_pkg::StScan;
      end
      rws_pkg::StScan: begin
        if (sts_i.hit || sts_i.last_elem) begin
          state_d = rws_pkg::StResult;
        end
      end
      rws_pkg::StResult: begin
        if (out_free) begin
          state_d = rws_pkg::StIdle;
        end
      end
      default: state_d = rws_pkg::StIdle;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_stall_o = 1'b1;
    unique case (state_q)
      rws_pkg::StIdle: begin
        in_stall_o     = 1'b0;
        cmd_o.write_en = in_valid_i && (in_cmd_i == rws_pkg::CmdWrite);
        cmd_o.capture  = in_valid_i && (in_cmd_i == rws_pkg::CmdSelect);
      end
      rws_pkg::StCheck: begin
      end
      rws_pkg::StSum: begin
        cmd_o.sum_step = 1'b1;
      end
      rws_pkg::StMul: begin
        cmd_o.mul_load = 1'b1;
      end
      rws_pkg::StScan: begin
        cmd_o.scan_step = 1'b1;
      end
      rws_pkg::StResult: begin
        cmd_o.out_load = out_free;
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= rws_pkg::StIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

@@ rtl/rws_datapath.sv @@
// Datapath with the fitness table, the running sums, the threshold multiplier and the result register.
module rws_datapath (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  rws_pkg::ctrl_cmd_t        cmd_i,
  input  rws_pkg::in_word_t         in_word_i,
  input  logic [rws_pkg::CfgW-1:0]  member_count_i,
  output rws_pkg::dp_status_t       sts_o,
  output rws_pkg::out_word_t        out_word_o
);

  logic [rws_pkg::FitW-1:0]  table_q [rws_pkg::MaxMembers];
  logic [rws_pkg::FracW-1:0] frac_q;
  logic [rws_pkg::MaskW-1:0] mask_q;
  logic [rws_pkg::IdxW-1:0]  last_q;
  logic [rws_pkg::IdxW-1:0]  cnt_q;
  logic [rws_pkg::IdxW-1:0]  pick_q;
  logic [rws_pkg::SumW-1:0]  total_q;
  logic [rws_pkg::SumW-1:0]  thresh_q;
  logic [rws_pkg::SumW-1:0]  running_q;
  logic [rws_pkg::SumW-1:0]  running_d;
  logic [rws_pkg::SumW-1:0]  contrib;
  logic [rws_pkg::SumW+rws_pkg::FracW-1:0] product;
  logic [rws_pkg::CntW-1:0]  n_q;
  logic [rws_pkg::CntW-1:0]  n_new;
  logic                      excl;
  logic                      mask_err;
  rws_pkg::out_word_t        out_q;

  assign n_new = rws_pkg::eff_count(member_count_i);

  always_comb begin
    mask_err = 1'b0;
    for (int i = 0; i < rws_pkg::MaskW; i++) begin
      if (i >= int'(n_q)) begin
        mask_err = mask_err | mask_q[i];
      end
    end
  end

  assign excl      = (int'(cnt_q) < rws_pkg::MaskW) && mask_q[rws_pkg::MaskIdxW'(cnt_q)];
  assign contrib   = excl ? '0 : rws_pkg::SumW'(table_q[cnt_q]);
  assign running_d = running_q + contrib;
  assign product   = (rws_pkg::SumW + rws_pkg::FracW)'(total_q) *
                     (rws_pkg::SumW + rws_pkg::FracW)'(frac_q);

  assign sts_o.mask_err  = mask_err;
  assign sts_o.last_elem = (cnt_q == last_q);
  assign sts_o.hit       = !excl && (thresh_q <= running_d);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < rws_pkg::MaxMembers; i++) begin
        table_q[i] <= '0;
      end
    end else if (cmd_i.write_en && (int'(in_word_i.member_index) < rws_pkg::MaxMembers)) begin
      table_q[rws_pkg::IdxW'(in_word_i.member_index)] <= in_word_i.fitness_value;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      frac_q  <= in_word_i.random_fraction;
      mask_q  <= in_word_i.exclude_mask;
      n_q     <= n_new;
      last_q  <= rws_pkg::IdxW'(n_new - rws_pkg::CntW'(1));
      cnt_q   <= '0;
      pick_q  <= '0;
      total_q <= '0;
    end
    if (cmd_i.sum_step) begin
      total_q <= total_q + contrib;
      cnt_q   <= cnt_q + rws_pkg::IdxW'(1);
    end
    if (cmd_i.mul_load) begin
      thresh_q  <= product[rws_pkg::SumW+rws_pkg::FracW-1:rws_pkg::FracW];
      running_q <= '0;
      cnt_q     <= '0;
    end
    if (cmd_i.scan_step) begin
      running_q <= running_d;
      cnt_q     <= cnt_q + rws_pkg::IdxW'(1);
      if (sts_o.hit) begin
        pick_q <= cnt_q;
      end
    end
    if (cmd_i.out_load) begin
      out_q.picked_index <= 4'(pick_q);
      out_q.status       <= mask_err ? rws_pkg::StatusMaskErr : rws_pkg::StatusOk;
    end
  end

  assign out_word_o = out_q;

endmodule

@@ rtl/roulette_wheel_select_core.sv @@
// Top level of the roulette wheel select core with its configuration register.
//
// Channel   Direction  Handshake              Word
// in        input      in_valid_i/in_stall_o  rws_pkg::in_word_t
// out       output     out_valid_o/out_stall_i rws_pkg::out_word_t
// cfg       input      APB psel/penable       member_count at byte address 0
//
// A write word updates the fitness table in the cycle it is accepted and gives no result.
// A select runs a sum pass and a prefix scan over the n members in use, each reading
// one table entry per cycle.
// A select with a mask bit beyond the member count skips both passes after the check.
// Reset clears the fitness table and sets the member count to sixteen.
// The next word is accepted while a finished result waits in the output register.
module roulette_wheel_select_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  rws_pkg::in_word_t              in_word_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output rws_pkg::out_word_t             out_word_o,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rws_pkg::CfgAddrW-1:0]   paddr,
  input  logic [rws_pkg::CfgDataW-1:0]   pwdata,
  output logic [rws_pkg::CfgDataW-1:0]   prdata,
  output logic                           pready
);

  logic [rws_pkg::CfgW-1:0] member_count_q;
  logic                     cfg_sel;
  rws_pkg::ctrl_cmd_t       cmd;
  rws_pkg::dp_status_t      sts;

  assign pready  = 1'b1;
  assign cfg_sel = (paddr[rws_pkg::CfgAddrW-1:2] == rws_pkg::RegMemberCount);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      member_count_q <= rws_pkg::MemberCountReset;
    end else if (psel && penable && pwrite && pready && cfg_sel) begin
      member_count_q <= pwdata[rws_pkg::CfgW-1:0];
    end
  end

  assign prdata = cfg_sel ? rws_pkg::CfgDataW'(member_count_q) : '0;

  rws_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_cmd_i    (in_word_i.cmd),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  rws_datapath u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .in_word_i      (in_word_i),
    .member_count_i (member_count_q),
    .sts_o          (sts),
    .out_word_o     (out_word_o)
  );

  a_select_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_word_i.cmd == rws_pkg::CmdSelect)) |=> in_stall_o)
    else $error("select word did not occupy the block");

  a_write_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && (in_word_i.cmd == rws_pkg::CmdWrite) && !out_valid_o)
    |=> !out_valid_o)
    else $error("write word produced a result");

  a_err_picks_zero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_word_o.status == rws_pkg::StatusMaskErr))
    |-> (out_word_o.picked_index == '0))
    else $error("mask error result with nonzero index");

endmodule
